FILE: hdl/stlo_pkg.sv
// Shared types and constants for the strided tensor linear offset block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stlo_pkg;

   // dimension counter width, saturates at all ones
   localparam int DIMS_W = 4;
   localparam logic [DIMS_W-1:0] RANK_RESET = DIMS_W'(1);
   localparam int MAX_RANK_DEF = 8;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // split of the 63-bit operands for the 32x32 multiplier
   localparam int HALF_W = 32;
   localparam int MUL_STEPS = 4;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANK     = 2'd1,
      ST_BOUNDS   = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [63:0] dim_index;
      logic [62:0]        dim_extent;
      logic [62:0]        dim_stride;
      logic               last_dim;
   } req_type;

   typedef struct packed {
      logic [62:0] element_offset;
      status_type  status;
   } rsp_type;

   // one classified dimension, handed from front to back
   typedef struct packed {
      logic [62:0] idx;
      logic [62:0] stride;
      logic        bounds_err;
      logic        no_product;
      logic        last;
      logic        rank_bad;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      B_IDLE = 2'd0,
      B_MUL  = 2'd1,
      B_ADD  = 2'd2,
      B_DONE = 2'd3
   } back_state_type;

endpackage

`default_nettype wire

FILE: hdl/stlo_front.sv
// Front end: accepts requests, checks bounds and dimension count, pushes a
// classified entry into the queue. Holds the expected_rank register. Uses stlo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stlo_front #(
   parameter int MAX_RANK = stlo_pkg::MAX_RANK_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  stlo_pkg::req_type           req_data,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [stlo_pkg::DIMS_W-1:0] csr_data,
   input  stlo_pkg::q_status_type      q_stat,
   output logic                        q_push,
   output stlo_pkg::q_entry_type       q_entry
);
   import stlo_pkg::*;

   localparam logic [DIMS_W-1:0] MaxRankVal = DIMS_W'(MAX_RANK);
   localparam logic [DIMS_W-1:0] DimsSat = '1;

   logic [DIMS_W-1:0] expected_rank_ff, expected_rank_in;
   logic [DIMS_W-1:0] dims_seen_ff, dims_seen_in;
   logic              too_long_ff, too_long_in;
   logic [DIMS_W-1:0] dims_next;
   logic              too_long_next;
   logic              accept;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept;

   // dimension count bookkeeping
   always_comb begin
      too_long_next    = too_long_ff || (dims_seen_ff >= MaxRankVal);
      dims_next        = (dims_seen_ff == DimsSat) ? DimsSat : dims_seen_ff + 1'b1;
      dims_seen_in     = dims_seen_ff;
      too_long_in      = too_long_ff;
      expected_rank_in = expected_rank_ff;
      if (csr_valid && csr_ready) begin
         expected_rank_in = csr_data;
      end
      if (accept) begin
         if (req_data.last_dim) begin
            dims_seen_in = '0;
            too_long_in  = 1'b0;
         end else begin
            dims_seen_in = dims_next;
            too_long_in  = too_long_next;
         end
      end
   end

   // classify the request
   always_comb begin
      q_entry.idx        = req_data.dim_index[62:0];
      q_entry.stride     = req_data.dim_stride;
      q_entry.bounds_err = req_data.dim_index[63] ||
                           (req_data.dim_index[62:0] >= req_data.dim_extent);
      q_entry.no_product = (req_data.dim_index[62:0] == '0) || (req_data.dim_stride == '0);
      q_entry.last       = req_data.last_dim;
      q_entry.rank_bad   = too_long_next || (expected_rank_ff > MaxRankVal) ||
                           (dims_next != expected_rank_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_rank_ff <= RANK_RESET;
         dims_seen_ff     <= '0;
         too_long_ff      <= 1'b0;
      end else begin
         expected_rank_ff <= expected_rank_in;
         dims_seen_ff     <= dims_seen_in;
         too_long_ff      <= too_long_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/stlo_queue.sv
// Short queue of classified dimensions between front and back.
// Uses stlo_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module stlo_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_push,
   input  stlo_pkg::q_entry_type  q_entry,
   input  wire                    q_pop,
   output stlo_pkg::q_entry_type  q_head,
   output stlo_pkg::q_status_type q_stat
);
   import stlo_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LastPtr = AW'(QUEUE_DEPTH - 1);
   localparam logic [AW:0] FullCount = (AW + 1)'(QUEUE_DEPTH);

   q_entry_type     entries_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;

   assign q_head       = entries_ff[rd_ptr_ff];
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == FullCount);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         entries_ff[wr_ptr_ff] <= q_entry;
      end
   end

   // never popped while empty
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   // count stays within the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: hdl/stlo_back.sv
// Back end: checked multiply-accumulate of one dimension at a time on a shared
// 32x32 multiplier, error tracking and the result register. Uses stlo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stlo_back (
   input  wire                    clock,
   input  wire                    reset,
   input  stlo_pkg::q_entry_type  q_head,
   input  stlo_pkg::q_status_type q_stat,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output stlo_pkg::rsp_type      rsp_data
);
   import stlo_pkg::*;

   localparam int SUM_W = 63 + HALF_W + 2;
   localparam logic [2:0] LastStep = 3'(MUL_STEPS);

   typedef enum logic [1:0] {
      SH_NONE = 2'd0,
      SH_MID  = 2'd1,
      SH_HIGH = 2'd2
   } pp_shift_type;

   back_state_type    state_ff, state_in;
   q_entry_type       work_ff, work_in;
   logic [62:0]       running_ff, running_in;
   status_type        first_error_ff, first_error_in;
   logic [2:0]        step_ff, step_in;
   logic [2*HALF_W-1:0] pp_ff, pp_in;
   pp_shift_type      pp_shift_ff, pp_shift_in;
   logic [62:0]       acc_ff, acc_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [HALF_W-1:0] idx_lo, idx_hi, str_lo, str_hi;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [SUM_W-1:0]  acc_sum;
   logic [63:0]       off_sum;
   status_type        final_status;
   logic              out_free;

   assign idx_lo = work_ff.idx[HALF_W-1:0];
   assign idx_hi = {1'b0, work_ff.idx[62:HALF_W]};
   assign str_lo = work_ff.stride[HALF_W-1:0];
   assign str_hi = {1'b0, work_ff.stride[62:HALF_W]};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // multiplier operand select per step
   always_comb begin
      case (step_ff)
         3'd0: begin
            mul_a = idx_lo;
            mul_b = str_lo;
         end
         3'd1: begin
            mul_a = idx_lo;
            mul_b = str_hi;
         end
         3'd2: begin
            mul_a = idx_hi;
            mul_b = str_lo;
         end
         default: begin
            mul_a = idx_hi;
            mul_b = str_hi;
         end
      endcase
   end

   // add the registered partial product at its weight
   always_comb begin
      case (pp_shift_ff)
         SH_NONE: acc_sum = SUM_W'(acc_ff) + SUM_W'(pp_ff);
         SH_MID:  acc_sum = SUM_W'(acc_ff) + SUM_W'({pp_ff, {HALF_W{1'b0}}});
         default: acc_sum = SUM_W'(acc_ff);
      endcase
   end

   assign off_sum      = {1'b0, running_ff} + {1'b0, acc_ff};
   assign final_status = work_ff.rank_bad ? ST_RANK : first_error_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      work_in        = work_ff;
      running_in     = running_ff;
      first_error_in = first_error_ff;
      step_in        = step_ff;
      pp_in          = pp_ff;
      pp_shift_in    = pp_shift_ff;
      acc_in         = acc_ff;
      ovf_in         = ovf_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      q_pop          = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               q_pop   = 1'b1;
               work_in = q_head;
               step_in = '0;
               acc_in  = '0;
               ovf_in  = 1'b0;
               if (first_error_ff == ST_OK && q_head.bounds_err) begin
                  first_error_in = ST_BOUNDS;
               end
               if (first_error_ff == ST_OK && !q_head.bounds_err && !q_head.no_product) begin
                  state_in = B_MUL;
               end else begin
                  state_in = B_DONE;
               end
            end
         end
         B_MUL: begin
            if (step_ff != LastStep) begin
               pp_in = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
               case (step_ff) inside
                  3'd0:       pp_shift_in = SH_NONE;
                  3'd1, 3'd2: pp_shift_in = SH_MID;
                  default:    pp_shift_in = SH_HIGH;
               endcase
            end
            if (step_ff != '0) begin
               acc_in = acc_sum[62:0];
               ovf_in = ovf_ff || (acc_sum[SUM_W-1:63] != '0) ||
                        (pp_shift_ff == SH_HIGH && pp_ff != '0);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = B_ADD;
            end
         end
         B_ADD: begin
            if (ovf_ff || off_sum[63]) begin
               first_error_in = ST_OVERFLOW;
            end else begin
               running_in = off_sum[62:0];
            end
            state_in = B_DONE;
         end
         B_DONE: begin
            if (!work_ff.last) begin
               state_in = B_IDLE;
            end else if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = final_status;
               rsp_data_in.element_offset = (final_status == ST_OK) ? running_ff : '0;
               running_in                 = '0;
               first_error_in             = ST_OK;
               state_in                   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         running_ff     <= '0;
         first_error_ff <= ST_OK;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         running_ff     <= running_in;
         first_error_ff <= first_error_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      pp_ff       <= pp_in;
      pp_shift_ff <= pp_shift_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an erroneous result carries a zero offset
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> (rsp_data_ff.element_offset == '0))
      else $error("nonzero offset with error status");

   // the queue is only drained from idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == B_IDLE && !q_stat.empty))
      else $error("pop outside idle");

   // multiply sequence never runs past its last step
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MUL) |-> (step_ff <= LastStep))
      else $error("multiply step out of range");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == B_DONE && work_ff.last) |=> (state_ff == B_DONE))
      else $error("result slot overwritten");

endmodule

`default_nettype wire

FILE: hdl/strided_tensor_linear_offset_core.sv
// A dimension with a nonzero product passes through the back-end states B_IDLE, B_MUL, B_ADD
// and B_DONE, a skipped or out-of-bounds one through B_IDLE and B_DONE; results are registered.
// One dimension at a time runs on the shared 32x32 multiplier and the checked adds, while the
// queue holds further ones; a result held by rsp_stall keeps the back end on the final dimension.
// Reset: synchronous; clears the tuple state, the queue and sets expected_rank to 1.
// Top level: instantiates stlo_front, stlo_queue and stlo_back; uses stlo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_linear_offset_core #(
   parameter int MAX_RANK = stlo_pkg::MAX_RANK_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  stlo_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output stlo_pkg::rsp_type           rsp_data,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [stlo_pkg::DIMS_W-1:0] csr_data
);
   import stlo_pkg::*;

   q_status_type q_stat;
   q_entry_type  q_entry;
   q_entry_type  q_head;
   logic         q_push;
   logic         q_pop;

   // request intake and classification
   stlo_front #(
      .MAX_RANK (MAX_RANK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // decoupling queue
   stlo_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_stat  (q_stat)
   );

   // checked accumulate and result
   stlo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: dv/strided_tensor_linear_offset_core_tb.sv
// Self-checking testbench for strided_tensor_linear_offset_core: directed edge cases,
// back-pressure and a random sweep over rank settings, checked against an in-bench predictor.
// Depends on stlo_pkg and the core RTL under hdl/.
`timescale 1ns / 1ps

module strided_tensor_linear_offset_core_tb;
   import stlo_pkg::*;

   localparam int          MAX_RANK    = MAX_RANK_DEF;
   localparam logic [63:0] MASK63      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          TAIL_CYCLES = 24;
   localparam int          CYCLE_LIMIT = 400000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [DIMS_W-1:0] csr_data;

   // predictor state for the tuple being walked
   logic [63:0]       tuple_offset;
   status_type        tuple_error;
   logic [DIMS_W-1:0] tuple_dims;
   logic              tuple_too_long;
   logic [DIMS_W-1:0] rank_setting;

   rsp_type     pending_offsets[$];
   int unsigned mismatch_count;

   // idling controls
   bit          send_idle;
   bit          recv_idle;
   int unsigned stall_left;
   int unsigned hold_left;

   strided_tensor_linear_offset_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** strided_tensor_linear_offset_core: FAILED **");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one dimension of the walk: bounds check, checked multiply and checked add
   task automatic predict_linear_offset(input req_type d);
      logic [63:0] idx;
      logic [63:0] ext;
      logic [63:0] str;
      logic [63:0] prod;
      status_type  st;
      rsp_type     r;
      idx = d.dim_index;
      ext = {1'b0, d.dim_extent};
      str = {1'b0, d.dim_stride};
      if (tuple_dims >= MAX_RANK) tuple_too_long = 1'b1;
      if (tuple_dims != '1) tuple_dims = tuple_dims + 1'b1;
      if (tuple_error == ST_OK) begin
         if (idx[63] || idx >= ext) begin
            tuple_error = ST_BOUNDS;
         end else if (idx != 0 && str != 0) begin
            if (idx > MASK63 / str) begin
               tuple_error = ST_OVERFLOW;
            end else begin
               prod = idx * str;
               if (tuple_offset > MASK63 - prod) tuple_error = ST_OVERFLOW;
               else tuple_offset = tuple_offset + prod;
            end
         end
      end
      if (d.last_dim) begin
         // count mismatch beats any earlier error
         if (tuple_too_long || rank_setting > MAX_RANK || tuple_dims != rank_setting)
            st = ST_RANK;
         else
            st = tuple_error;
         r.status         = st;
         r.element_offset = (st == ST_OK) ? tuple_offset[62:0] : '0;
         pending_offsets.push_back(r);
         tuple_offset   = '0;
         tuple_error    = ST_OK;
         tuple_dims     = '0;
         tuple_too_long = 1'b0;
      end
   endtask

   // result checker; also draws the receiver's wait before the next result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_offsets.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual offset %h status %0d",
                     $time, rsp_data.element_offset, rsp_data.status);
            mismatch_count++;
         end else begin
            if (rsp_data.element_offset !== pending_offsets[0].element_offset) begin
               $display("%0t: element_offset mismatch: expected %h, actual %h", $time,
                        pending_offsets[0].element_offset, rsp_data.element_offset);
               mismatch_count++;
            end
            if (rsp_data.status !== pending_offsets[0].status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                        pending_offsets[0].status, rsp_data.status);
               mismatch_count++;
            end
            void'(pending_offsets.pop_front());
         end
         stall_left = recv_idle ? $urandom_range(0, 13) : 0;
      end
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // send one request; entered and left just after a falling edge
   task automatic send_dim(input req_type d);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = d;
      do @(posedge clock); while (req_stall);
      predict_linear_offset(d);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_fields(input logic [63:0] idx, input logic [63:0] ext,
                              input logic [63:0] str, input bit last);
      req_type d;
      d.dim_index  = idx;
      d.dim_extent = ext[62:0];
      d.dim_stride = str[62:0];
      d.last_dim   = last;
      send_dim(d);
   endtask

   // wait for every expected result, then let the pipeline settle
   task automatic drain_offsets(input int unsigned tail);
      req_valid = 1'b0;
      while (pending_offsets.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic set_expected_rank(input logic [DIMS_W-1:0] value);
      drain_offsets(TAIL_CYCLES);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      rank_setting = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random dimension; clean ones stay in bounds and far from overflow
   function automatic req_type make_dim(input bit last, input bit clean);
      req_type     d;
      logic [63:0] idx;
      logic [63:0] ext;
      logic [63:0] str;
      int unsigned pick;
      int unsigned k;
      pick = clean ? (($urandom_range(0, 9) == 0) ? 88 : 0) : $urandom_range(0, 99);
      idx  = '0;
      ext  = MASK63;
      str  = '0;
      if (pick < 55) begin
         // in bounds, product below 2^59
         k   = $urandom_range(0, 28);
         idx = rand64() & ((64'd1 << k) - 1);
         str = rand64() & ((64'd1 << (59 - k)) - 1);
         if ($urandom_range(0, 3) == 0) ext = idx + 1;
         else ext = idx + 1 + (rand64() & ((64'd1 << $urandom_range(0, 61)) - 1));
      end else if (pick < 65) begin
         // huge stride, tiny index: sums overflow over a few dimensions
         idx = $urandom_range(0, 3);
         str = (64'd1 << 61) | (rand64() & ((64'd1 << 61) - 1));
         ext = idx + 1 + $urandom_range(0, 7);
      end else if (pick < 75) begin
         // product right at or just past the signed limit
         k   = $urandom_range(1, 62);
         idx = (64'd1 << k) | (rand64() & ((64'd1 << k) - 1));
         str = MASK63 / idx;
         if ($urandom_range(0, 1) == 0) str = str + 1;
      end else if (pick < 85) begin
         // out of bounds
         str = rand64() & MASK63;
         case ($urandom_range(0, 3))
            0: begin
               idx = rand64() | (64'd1 << 63);
               ext = rand64() & MASK63;
            end
            1: begin
               ext = rand64() & (MASK63 >> $urandom_range(0, 62));
               idx = ext;
            end
            2: begin
               ext = '0;
               idx = rand64() >> $urandom_range(0, 63);
            end
            default: begin
               ext = rand64() & (MASK63 >> $urandom_range(0, 62));
               idx = ext + 1 + (rand64() & (MASK63 >> $urandom_range(0, 62)));
            end
         endcase
      end else if (pick < 92) begin
         // zero index or zero stride
         ext = (rand64() & MASK63) | 64'd1;
         if ($urandom_range(0, 1) == 0) begin
            idx = '0;
            str = rand64() & MASK63;
         end else begin
            idx = rand64() % ext;
            str = '0;
         end
      end else begin
         idx = rand64();
         ext = rand64() & MASK63;
         str = rand64() & MASK63;
      end
      d.dim_index  = idx;
      d.dim_extent = ext[62:0];
      d.dim_stride = str[62:0];
      d.last_dim   = last;
      return d;
   endfunction

   task automatic send_tuple(input int unsigned len, input bit clean);
      for (int i = 0; i < len; i++) send_dim(make_dim(i == len - 1, clean));
   endtask

   // single-dimension tuples at the edges of every field
   task automatic test_single_dim_edges();
      set_expected_rank(4'd1);
      send_fields(64'd0, 64'd1, MASK63, 1'b1);
      send_fields(64'd1, MASK63, MASK63, 1'b1);
      send_fields(MASK63 - 1, MASK63, 64'd1, 1'b1);
      send_fields('1, MASK63, 64'd1, 1'b1);
      send_fields(64'h8000_0000_0000_0000, MASK63, 64'd1, 1'b1);
      send_fields(64'd5, 64'd5, 64'd1, 1'b1);
      send_fields(64'd0, 64'd0, 64'd1, 1'b1);
      send_fields(64'd2, 64'd3, 64'd1 << 62, 1'b1);
      send_fields(MASK63 - 1, MASK63, 64'd0, 1'b1);
   endtask

   // sum overflow, first error wins, count mismatch wins, ranks out of range
   task automatic test_tuple_rules();
      set_expected_rank(4'd2);
      send_fields(64'd1, 64'd2, 64'd1 << 62, 1'b0);
      send_fields(64'd1, 64'd2, 64'd1 << 62, 1'b1);
      send_fields(64'd7, 64'd3, 64'd1, 1'b0);
      send_fields(64'd2, 64'd3, 64'd1 << 62, 1'b1);
      send_fields(64'd9, 64'd3, 64'd1, 1'b1);
      send_fields(64'd1, 64'd4, 64'd10, 1'b0);
      send_fields(64'd2, 64'd4, 64'd100, 1'b0);
      send_fields(64'd3, 64'd4, 64'd1000, 1'b1);
      set_expected_rank(4'd9);
      send_fields(64'd1, 64'd4, 64'd10, 1'b1);
      set_expected_rank(4'd0);
      send_fields(64'd1, 64'd4, 64'd10, 1'b1);
      set_expected_rank(4'd15);
      send_fields(64'd1, 64'd4, 64'd10, 1'b1);
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      set_expected_rank(4'd1);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      hold_left = 160;
      for (int i = 0; i < 40; i++) send_dim(make_dim(1'b1, 1'b1));
      drain_offsets(0);
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // random tuples, one rank setting per phase, mostly well-formed
   task automatic test_random_sweep();
      logic [DIMS_W-1:0] ranks[14];
      int unsigned       sent;
      int unsigned       len;
      ranks = '{4'd8, 4'd1, 4'd3, 4'd2, 4'd5, 4'd7, 4'd4, 4'd6, 4'd8, 4'd15, 4'd0, 4'd9,
                4'd1, 4'd8};
      for (int p = 0; p < 14; p++) begin
         set_expected_rank(ranks[p]);
         send_idle = (p % 3) != 0;
         recv_idle = (p % 4) != 1;
         sent = 0;
         while (sent < 100) begin
            if (ranks[p] >= 1 && ranks[p] <= MAX_RANK && $urandom_range(0, 4) != 0)
               len = ranks[p];
            else
               len = $urandom_range(1, 17);
            send_tuple(len, $urandom_range(0, 9) < 7);
            sent += len;
            // sender pauses until every result is back
            if ($urandom_range(0, 39) == 0) drain_offsets(0);
         end
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      tuple_offset   = '0;
      tuple_error    = ST_OK;
      tuple_dims     = '0;
      tuple_too_long = 1'b0;
      rank_setting   = RANK_RESET;
      mismatch_count = 0;
      send_idle      = 1'b1;
      recv_idle      = 1'b1;
      stall_left     = 0;
      hold_left      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_dim_edges();
      test_tuple_rules();
      test_backpressure();
      test_random_sweep();

      drain_offsets(TAIL_CYCLES);
      if (mismatch_count == 0) begin
         $display("** strided_tensor_linear_offset_core: PASSED **");
      end else begin
         $display("** strided_tensor_linear_offset_core: FAILED **");
      end
      $finish;
   end

endmodule
